### src/length_crc32_deframer_unit_assert.svh
// Assertion macros for the deframer. Under synthesis they expand to nothing.
`ifndef LENGTH_CRC32_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_CRC32_DEFRAMER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define LDF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must never be true outside reset.
`define LDF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LDF_ASSERT(label, clk, rst_n, prop, msg)
`define LDF_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### src/ldf_pkg.sv
package ldf_pkg;

	// Trailer length in bytes and the index of its last byte.
	localparam int CRC_BYTES = 4;
	localparam logic [1:0] CRC_LAST = 2'(CRC_BYTES - 1);

	// Frame status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CRC_BAD  = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	// Result queue geometry.
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCW    = 3;

	localparam logic [31:0] CRC_POLY_REFLECTED = 32'hEDB88320;

	// One result item as it travels through the queue.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_status;
		logic       frame_last;
		logic [1:0] status_code;
	} ldf_result_t;

	// Write request from the parser into the queue.
	typedef struct packed {
		logic        push;
		ldf_result_t res;
	} ldf_push_t;

	// Reflected CRC-32 update over one byte.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### src/length_crc32_deframer_unit.sv
// Length-prefixed frame deframer with CRC-32 check. Each input request carries one byte of
// a stream made of a little-endian length header (LENGTH_BYTES bytes), the body, and a
// little-endian CRC-32 trailer (reflected 0x04C11DB7, init and final xor all ones) over the
// body. Body bytes come out as soon as they arrive; the last trailer byte yields one status
// result with frame_last set (ok or checksum mismatch), and a header announcing more than
// max_body_length bytes yields a too-long status at once, after which a new header is
// expected. The block takes one byte per cycle while its result queue has room: the parser
// and its byte-wide CRC update finish within the cycle of acceptance, and its result is
// registered in a four-entry queue that drives the output. in_ready drops only while that
// queue is full, so a stalled output stops the input after four pending results.
`include "length_crc32_deframer_unit_assert.svh"
module length_crc32_deframer_unit import ldf_pkg::*; #(
	parameter int LENGTH_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        is_status,
	output logic        frame_last,
	output logic [1:0]  status_code
);

	ldf_push_t        wr;
	ldf_result_t      rd_data;
	logic             take;
	logic             pop;
	logic             full;
	logic [QCW-1:0]   q_count;

	// Handshakes on both sides.
	assign in_ready = !full;
	assign take     = in_valid && in_ready;
	assign pop      = out_valid && out_ready;

	ldf_front #(
		.LENGTH_BYTES(LENGTH_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.take       (take),
		.in_byte    (in_byte),
		.wr         (wr)
	);

	ldf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.pop     (pop),
		.full    (full),
		.count   (q_count),
		.rd_valid(out_valid),
		.rd_data (rd_data)
	);

	// Result fields to the output ports.
	assign out_byte    = rd_data.out_byte;
	assign is_status   = rd_data.is_status;
	assign frame_last  = rd_data.frame_last;
	assign status_code = rd_data.status_code;

	`LDF_ASSERT_NEVER(a_no_overflow, clk, arst_n, wr.push && full, "result pushed into a full queue")
	`LDF_ASSERT(a_push_needs_take, clk, arst_n, !wr.push || take, "result pushed without an accepted request")
	`LDF_ASSERT(a_count_up, clk, arst_n, (wr.push && !pop) |=> (q_count == $past(q_count) + QCW'(1)), "queue count did not grow on push")
	`LDF_ASSERT(a_status_last, clk, arst_n, !(out_valid && is_status) || (frame_last && out_byte == 8'h00), "status result without frame_last or with a data byte")

endmodule

### src/ldf_front.sv
module ldf_front import ldf_pkg::*; #(
	parameter int LENGTH_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	input  logic        take,
	input  logic [7:0]  in_byte,
	output ldf_push_t   wr
);

	localparam int LW = 8 * LENGTH_BYTES;
	localparam logic [1:0] HDR_LAST = 2'(LENGTH_BYTES - 1);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_BODY    = 2'd1;
	localparam logic [1:0] PH_TRAILER = 2'd2;

	logic [1:0]    phase_q, phase_d;
	logic [1:0]    cnt_q, cnt_d;
	logic [LW-1:0] len_q, len_d;
	logic [LW-1:0] rem_q, rem_d;
	logic [31:0]   crc_q, crc_d;
	logic [31:0]   rx_q, rx_d;
	logic [23:0]   max_q;

	logic [LW-1:0] hdr_len;
	logic [31:0]   rx_cat;
	logic [31:0]   crc_upd;
	logic [4:0]    sh;

	// Byte lane of the current header or trailer byte.
	assign sh      = {cnt_q, 3'b000};
	assign hdr_len = ((cnt_q == 2'd0) ? '0 : len_q) | (LW'(in_byte) << sh);
	assign rx_cat  = rx_q | (32'(in_byte) << sh);
	assign crc_upd = crc_byte(crc_q, in_byte);

	// Parser: next state and the result request for the byte on the input.
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		len_d   = len_q;
		rem_d   = rem_q;
		crc_d   = crc_q;
		rx_d    = rx_q;
		wr      = '0;
		unique case (phase_q)
			PH_BODY: begin
				crc_d = crc_upd;
				rem_d = rem_q - LW'(1);
				if (rem_q == LW'(1)) begin
					phase_d = PH_TRAILER;
					cnt_d   = 2'd0;
					rx_d    = 32'h0;
				end
				wr.push         = 1'b1;
				wr.res.out_byte = in_byte;
			end
			PH_TRAILER: begin
				if (cnt_q == CRC_LAST) begin
					phase_d               = PH_HEADER;
					cnt_d                 = 2'd0;
					wr.push               = 1'b1;
					wr.res.is_status      = 1'b1;
					wr.res.frame_last     = 1'b1;
					wr.res.status_code    = (rx_cat == ~crc_q) ? ST_OK : ST_CRC_BAD;
				end else begin
					rx_d  = rx_cat;
					cnt_d = cnt_q + 2'd1;
				end
			end
			default: begin
				// Header phase; the unused phase code behaves the same way.
				len_d = hdr_len;
				if (cnt_q != HDR_LAST) begin
					phase_d = PH_HEADER;
					cnt_d   = cnt_q + 2'd1;
				end else begin
					cnt_d = 2'd0;
					crc_d = 32'hFFFFFFFF;
					rx_d  = 32'h0;
					if (32'(hdr_len) > {8'h00, max_q}) begin
						phase_d            = PH_HEADER;
						rem_d              = '0;
						wr.push            = 1'b1;
						wr.res.is_status   = 1'b1;
						wr.res.frame_last  = 1'b1;
						wr.res.status_code = ST_TOO_LONG;
					end else begin
						rem_d   = hdr_len;
						phase_d = (hdr_len == '0) ? PH_TRAILER : PH_BODY;
					end
				end
			end
		endcase
		// Only an accepted request may leave a result in the queue.
		wr.push = wr.push && take;
	end

	// Parser state advances only on an accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= 2'd0;
			len_q   <= '0;
			rem_q   <= '0;
			crc_q   <= 32'hFFFFFFFF;
			rx_q    <= 32'h0;
		end else if (take) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			crc_q   <= crc_d;
			rx_q    <= rx_d;
		end
	end

	// Maximum body length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= 24'd4096;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

endmodule

### src/ldf_queue.sv
module ldf_queue import ldf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ldf_push_t   wr,
	input  logic        pop,
	output logic        full,
	output logic [QCW-1:0] count,
	output logic        rd_valid,
	output ldf_result_t rd_data
);

	ldf_result_t      mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic             do_pop;

	assign do_pop   = pop && (count_q != '0);
	assign full     = (count_q == QCW'(QDEPTH));
	assign count    = count_q;
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	// Result storage; entries need no reset.
	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.res;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + QCW'(wr.push) - QCW'(do_pop);
		end
	end

endmodule

### sim/length_crc32_deframer_checker.sv
package deframer_tb_pkg;

	// Reflected CRC-32 register advanced by one byte, least significant bit first.
	function automatic logic [31:0] crc32_shift(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] r;
		logic        fb;
		r = crc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = r >> 1;
			if (fb) begin
				r = r ^ ldf_pkg::CRC_POLY_REFLECTED;
			end
		end
		return r;
	endfunction

endpackage

module length_crc32_deframer_checker import ldf_pkg::*; import deframer_tb_pkg::*; #(
	parameter int LENGTH_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        is_status,
	input  logic        frame_last,
	input  logic [1:0]  status_code,
	output int          mismatches,
	output int          awaited,
	output logic        frame_boundary
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		PARSE_HEADER  = 2'd0,
		PARSE_BODY    = 2'd1,
		PARSE_TRAILER = 2'd2
	} parse_phase_t;

	// Shadow copy of the parser state and of the length limit.
	parse_phase_t phase;
	logic [1:0]   field_cnt;
	logic [31:0]  frame_len;
	logic [31:0]  body_left;
	logic [31:0]  crc_acc;
	logic [31:0]  crc_rx;
	logic [23:0]  max_len;

	// Results still owed by the block, oldest first.
	ldf_result_t awaited_results[$];
	ldf_result_t want;
	ldf_result_t predicted;
	logic        has_result;

	// Advance the shadow parser by one received byte; at most one result comes of it.
	function automatic void deframe_byte(input logic [7:0] b, output logic has_res,
			output ldf_result_t res);
		logic [4:0] sh;
		sh = {field_cnt, 3'b000};
		has_res = 1'b0;
		res = '0;
		case (phase)
			PARSE_BODY: begin
				crc_acc = crc32_shift(crc_acc, b);
				body_left = body_left - 32'd1;
				if (body_left == 32'd0) begin
					phase = PARSE_TRAILER;
					field_cnt = 2'd0;
					crc_rx = '0;
				end
				has_res = 1'b1;
				res.out_byte = b;
			end
			PARSE_TRAILER: begin
				crc_rx = crc_rx | (32'(b) << sh);
				if (field_cnt == CRC_LAST) begin
					phase = PARSE_HEADER;
					field_cnt = 2'd0;
					has_res = 1'b1;
					res.is_status = 1'b1;
					res.frame_last = 1'b1;
					res.status_code = (crc_rx == ~crc_acc) ? ST_OK : ST_CRC_BAD;
				end else begin
					field_cnt = field_cnt + 2'd1;
				end
			end
			default: begin
				// Header bytes arrive least significant first.
				if (field_cnt == 2'd0) begin
					frame_len = '0;
				end
				frame_len = frame_len | (32'(b) << sh);
				if (32'(field_cnt) + 1 < LENGTH_BYTES) begin
					phase = PARSE_HEADER;
					field_cnt = field_cnt + 2'd1;
				end else begin
					field_cnt = 2'd0;
					crc_acc = '1;
					crc_rx = '0;
					if (frame_len > 32'(max_len)) begin
						phase = PARSE_HEADER;
						body_left = '0;
						has_res = 1'b1;
						res.is_status = 1'b1;
						res.frame_last = 1'b1;
						res.status_code = ST_TOO_LONG;
					end else begin
						body_left = frame_len;
						phase = (frame_len == 32'd0) ? PARSE_TRAILER : PARSE_BODY;
					end
				end
			end
		endcase
	endfunction

	// Predict on every accepted input request and compare every accepted result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PARSE_HEADER;
			field_cnt = 2'd0;
			frame_len = '0;
			body_left = '0;
			crc_acc = '1;
			crc_rx = '0;
			max_len = 24'd4096;
			awaited_results.delete();
			mismatches <= 0;
			awaited <= 0;
			frame_boundary <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				max_len = cfg_wr_data;
			end
			if (in_valid && in_ready) begin
				deframe_byte(in_byte, has_result, predicted);
				if (has_result) begin
					awaited_results.push_back(predicted);
				end
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) begin
						$display("%0t: unexpected result byte %02h status %b last %b code %0d",
							$realtime, out_byte, is_status, frame_last, status_code);
					end
				end else begin
					want = awaited_results.pop_front();
					if (out_byte !== want.out_byte || is_status !== want.is_status ||
							frame_last !== want.frame_last ||
							status_code !== want.status_code) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10) begin
							$display({"%0t: result mismatch, expected byte %02h status %b ",
								"last %b code %0d, got byte %02h status %b last %b code %0d"},
								$realtime, want.out_byte, want.is_status, want.frame_last,
								want.status_code, out_byte, is_status, frame_last,
								status_code);
						end
					end
				end
			end
			awaited <= awaited_results.size();
			frame_boundary <= (phase == PARSE_HEADER) && (field_cnt == 2'd0);
		end
	end

endmodule

### sim/tb_length_crc32_deframer_unit.sv
module tb_length_crc32_deframer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import deframer_tb_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_CYCLES     = 150;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [23:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        is_status;
	logic        frame_last;
	logic [1:0]  status_code;

	int          mismatches;
	int          awaited;
	logic        frame_boundary;

	// Sender state and the length limit currently programmed.
	logic [23:0] max_setting;
	int          gap_max;
	int          burst_left;
	int          sent_bytes;
	int          hold_requests;
	int          cycle_count;

	// Receiver state.
	int          rx_cycle;
	int          stall_pct;
	int          hold_left;
	int          holds_served;

	length_crc32_deframer_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.is_status   (is_status),
		.frame_last  (frame_last),
		.status_code (status_code)
	);

	length_crc32_deframer_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.is_status      (is_status),
		.frame_last     (frame_last),
		.status_code    (status_code),
		.mismatches     (mismatches),
		.awaited        (awaited),
		.frame_boundary (frame_boundary)
	);

	always #2 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// The receiver stalls at a rate that is redrawn at random periodically, and holds off
	// for a long stretch whenever the stimulus asks for it.
	initial begin
		out_ready = 1'b0;
		rx_cycle = 0;
		stall_pct = 0;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle % 300 == 0) begin
				case ($urandom_range(4))
					0, 1: stall_pct = 0;
					2: stall_pct = 30;
					3: stall_pct = 60;
					default: stall_pct = 85;
				endcase
			end
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one byte and wait for its request to be accepted; bursts end in random gaps.
	task automatic send_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		sent_bytes++;
		if (gap_max > 0) begin
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				in_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
		end
	endtask

	// Stop sending and wait until every owed result has come out.
	task automatic settle_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [23:0] v);
		settle_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		max_setting = v;
	endtask

	// Header, then body and trailer unless the length is over the limit. The trailer is
	// the true CRC with the bits of crc_flip inverted.
	task automatic send_frame(input logic [31:0] len, input logic [7:0] body[$],
			input logic [31:0] crc_flip);
		logic [31:0] crc;
		crc = '1;
		for (int i = 0; i < 4; i++) begin
			send_byte(len[8*i +: 8]);
		end
		if (len > 32'(max_setting)) begin
			return;
		end
		foreach (body[i]) begin
			send_byte(body[i]);
			crc = crc32_shift(crc, body[i]);
		end
		crc = ~crc ^ crc_flip;
		for (int i = 0; i < 4; i++) begin
			send_byte(crc[8*i +: 8]);
		end
	endtask

	// Mostly well-formed frames with random content, some too-long headers, and with a
	// small limit some stray bytes that knock the parser out of step.
	task automatic random_frame(input bit allow_noise);
		logic [31:0] len;
		logic [31:0] flip;
		logic [7:0]  body[$];
		int          pick;
		pick = $urandom_range(99);
		if (allow_noise && pick < 8) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			// All-ones bytes finish any header as too long and run out any short body.
			in_valid <= 1'b0;
			@(posedge clk);
			while (!frame_boundary) begin
				send_byte(8'hFF);
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end else if (pick < 22) begin
			if ($urandom_range(1) == 0) begin
				len = 32'(max_setting) + 32'($urandom_range(1, 4));
			end else begin
				len = {8'($urandom_range(1, 255)), 24'($urandom)};
			end
			send_frame(len, body, 32'h0);
		end else begin
			if (max_setting <= 24'd64) begin
				if ($urandom_range(3) == 0) begin
					len = 32'(max_setting);
				end else begin
					len = $urandom_range(0, 32'(max_setting));
				end
			end else if ($urandom_range(24) == 0) begin
				len = $urandom_range(64, 200);
			end else begin
				len = $urandom_range(0, 24);
			end
			repeat (len) body.push_back(8'($urandom));
			case ($urandom_range(7))
				0: flip = 32'h1 << $urandom_range(31);
				1: flip = $urandom | 32'h1;
				default: flip = '0;
			endcase
			send_frame(len, body, flip);
		end
	endtask

	initial begin
		logic [7:0]  body[$];
		logic [23:0] limit;
		int          phase_start;
		bit          paused_once;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		in_byte = '0;
		max_setting = 24'd4096;
		gap_max = 2;
		burst_left = 1;
		sent_bytes = 0;
		hold_requests = 0;
		cycle_count = 0;
		paused_once = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty body with good and bad trailers, all-zero and all-ones body bytes,
		// and the largest possible length.
		send_frame(32'd0, body, 32'h0);
		send_frame(32'd0, body, 32'hFFFFFFFF);
		body = '{8'h00, 8'hFF};
		send_frame(32'd2, body, 32'h0);
		send_frame(32'hFFFFFFFF, body, 32'h0);

		// Random phases, each under its own length limit and sender rhythm.
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin limit = 24'd16; gap_max = 3; end
				1: begin limit = 24'd0; gap_max = 0; end
				2: begin limit = 24'd4096; gap_max = 2; end
				3: begin limit = 24'hFFFFFF; gap_max = 0; end
				4: begin limit = 24'd3; gap_max = 8; end
				5: begin limit = 24'd64; gap_max = 1; end
				default: begin limit = 24'($urandom_range(1, 40)); gap_max = 4; end
			endcase
			write_max_length(limit);
			phase_start = sent_bytes;
			while (sent_bytes - phase_start < ITEMS_PER_PHASE) begin
				random_frame(max_setting <= 24'd64);
				if (p == 2 && hold_requests == 0 &&
						sent_bytes - phase_start > ITEMS_PER_PHASE / 3) begin
					hold_requests++;
				end
				if (p == 3 && !paused_once && sent_bytes - phase_start > ITEMS_PER_PHASE / 2) begin
					settle_results();
					paused_once = 1'b1;
				end
			end
		end

		settle_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### files.f
+incdir+src
src/ldf_pkg.sv
src/ldf_front.sv
src/ldf_queue.sv
src/length_crc32_deframer_unit.sv
sim/length_crc32_deframer_checker.sv
sim/tb_length_crc32_deframer_unit.sv
